// ===== sv/prx_pkg.sv =====
// Package for the packet receiver with ACK/NAK replies.
// Holds the item types, action and status codes and length word constants.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package prx_pkg;

    // Action codes of an input item.
    localparam logic [1:0] ACT_HEADER  = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_START   = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_REPLY = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_DEST_BASE = 1'b1;

    // Length word bits.
    localparam logic [15:0] LEN_CRC_ERR = 16'h2000;
    localparam logic [15:0] LEN_QUERY   = 16'h4000;
    localparam logic [15:0] LEN_LAST    = 16'h1000;
    localparam logic [15:0] LEN_MASK    = 16'h0FFF;
    localparam int          LAST_BIT    = 12;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  pkt_sn;
        logic [15:0] pkt_len_word;
        logic        crc_match;
        logic        store_fail;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  reply_sn;
        logic [15:0] reply_len_word;
        logic        store_write;
        logic [31:0] store_address;
        logic [11:0] store_length;
        logic [19:0] total_bytes;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/packet_receiver_ack_nak_top.sv =====
// Top level of the packet receiver with ACK/NAK replies.
// Instantiates prx_in_stage, prx_core and prx_out_stage; uses prx_pkg.
//
// Usage: each item on the slave stream is one event of the link: a received
// packet header (with the outside CRC check result and the payload store
// outcome), a receive timeout or a request to start a new transfer. For every
// item exactly one result item leaves on the master stream: an ACK or NAK
// reply, a wait indication, or the end packet of a transfer (done or error),
// together with the payload store request for a data packet.
// Capacity and destination base must be written through the cfg_* port
// while the block is idle; the block itself does not enforce this. Writes
// take effect at the next clock edge. Path: an accepted item waits in the
// input register, is decided by prx_core and is loaded into the result
// register once that register has room.
// Throughput is one item per cycle unless m_axis_tready is low; the link
// state is a handful of counters updated in the cycle the decision is made.
// Stalls: when m_axis_tready is low the result register holds its item, the
// input register still takes one more item, and s_axis_tready then drops
// until the result is taken. Reset clears both registers' valid flags, the
// link state (idle) and both configuration registers.
`default_nettype none

module packet_receiver_ack_nak_top
#(
    parameter int NAK_LIMIT   = 3,
    parameter int RETRY_LIMIT = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port: index 0 capacity, index 1 dest_base.
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_data,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // From bit 0: pkt_sn[7:0], pkt_len_word[23:8], crc_match[24],
    // store_fail[25], zero padding[31:26].
    input  wire logic [31:0] s_axis_tdata,
    // action[1:0].
    input  wire logic [1:0]  s_axis_tuser,
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // From bit 0: reply_sn[7:0], reply_len_word[23:8], store_write[24],
    // store_address[56:25], store_length[68:57], total_bytes[88:69],
    // zero padding[95:89].
    output logic [95:0]      m_axis_tdata,
    // status[1:0].
    output logic [1:0]       m_axis_tuser
);

    prx_pkg::in_item_t  s_item;
    prx_pkg::in_item_t  cur_item;
    prx_pkg::out_item_t result;
    prx_pkg::out_item_t m_item;
    logic               cur_valid;
    logic               can_load;
    logic               advance;

    assign s_item.action       = s_axis_tuser;
    assign s_item.pkt_sn       = s_axis_tdata[7:0];
    assign s_item.pkt_len_word = s_axis_tdata[23:8];
    assign s_item.crc_match    = s_axis_tdata[24];
    assign s_item.store_fail   = s_axis_tdata[25];

    // The held item is decided when the result register has room for it.
    assign advance = cur_valid && can_load;

    prx_in_stage u_in
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .advance (advance),
        .valid   (cur_valid),
        .item    (cur_item)
    );

    prx_core
    #(
        .NAK_LIMIT   (NAK_LIMIT),
        .RETRY_LIMIT (RETRY_LIMIT)
    )
    u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .fire     (advance),
        .item     (cur_item),
        .result   (result)
    );

    prx_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_item   (m_item)
    );

    assign m_axis_tuser  = m_item.status;
    assign m_axis_tdata  = {7'd0,
                            m_item.total_bytes,
                            m_item.store_length,
                            m_item.store_address,
                            m_item.store_write,
                            m_item.reply_len_word,
                            m_item.reply_sn};

endmodule

`default_nettype wire

// ===== sv/prx_in_stage.sv =====
// Input register of the packet receiver.
// Holds one accepted item until the decision stage takes it; uses prx_pkg.
`default_nettype none

module prx_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire prx_pkg::in_item_t s_item,
    input  wire logic              advance,
    output logic                   valid,
    output prx_pkg::in_item_t      item
);

    logic              valid_reg;
    logic              valid_next;
    prx_pkg::in_item_t item_reg;

    // The register can load whenever it is empty or its item moves on this cycle.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

// ===== sv/prx_core.sv =====
// Decision logic of the packet receiver: link state, configuration registers
// and the per-item reply computation. Uses prx_pkg.
`default_nettype none

module prx_core
#(
    parameter int NAK_LIMIT   = 3,
    parameter int RETRY_LIMIT = 3
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               fire,
    input  wire prx_pkg::in_item_t  item,
    output prx_pkg::out_item_t      result
);

    logic [19:0] capacity_reg;
    logic [31:0] dest_base_reg;

    logic [7:0]  expected_sn_reg,    expected_sn_next;
    logic [2:0]  nak_count_reg,      nak_count_next;
    logic [1:0]  retry_count_reg,    retry_count_next;
    logic [19:0] received_total_reg, received_total_next;
    logic        last_seen_reg,      last_seen_next;
    logic        active_reg,         active_next;

    logic [11:0] len;
    logic [20:0] sum;
    logic        overflow;
    logic        good;
    logic [1:0]  retry_inc;
    logic [3:0]  nak_inc;

    assign len       = item.pkt_len_word[11:0];
    assign sum       = {1'b0, received_total_reg} + {9'd0, len};
    assign overflow  = sum > {1'b0, capacity_reg};
    assign good      = item.crc_match && (item.pkt_sn == expected_sn_reg);
    assign retry_inc = retry_count_reg + 2'd1;
    assign nak_inc   = {1'b0, nak_count_reg} + 4'd1;

    always_comb
    begin
        result              = '0;
        result.status       = prx_pkg::ST_WAIT;
        expected_sn_next    = expected_sn_reg;
        nak_count_next      = nak_count_reg;
        retry_count_next    = retry_count_reg;
        received_total_next = received_total_reg;
        last_seen_next      = last_seen_reg;
        active_next         = active_reg;

        if (item.action == prx_pkg::ACT_START)
        begin
            expected_sn_next    = '0;
            nak_count_next      = '0;
            retry_count_next    = '0;
            received_total_next = '0;
            last_seen_next      = 1'b0;
            active_next         = 1'b1;
        end
        else if (active_reg && item.action == prx_pkg::ACT_TIMEOUT)
        begin
            retry_count_next = retry_inc;
            if ({30'd0, retry_inc} >= 32'(RETRY_LIMIT))
            begin
                result.status         = prx_pkg::ST_ERROR;
                result.reply_len_word = prx_pkg::LEN_LAST;
                active_next           = 1'b0;
            end
        end
        else if (active_reg && item.action == prx_pkg::ACT_HEADER)
        begin
            retry_count_next = '0;
            if (good)
            begin
                nak_count_next = '0;
                if (overflow)
                begin
                    result.status         = prx_pkg::ST_ERROR;
                    result.reply_len_word = prx_pkg::LEN_LAST;
                    active_next           = 1'b0;
                end
                else if (item.pkt_len_word == prx_pkg::LEN_QUERY)
                begin
                    expected_sn_next = item.pkt_sn + 8'd1;
                    if (last_seen_reg)
                    begin
                        // Query after the last packet closes the transfer.
                        result.status         = prx_pkg::ST_DONE;
                        result.reply_len_word = prx_pkg::LEN_LAST;
                        result.total_bytes    = received_total_reg;
                        active_next           = 1'b0;
                    end
                    else
                    begin
                        result.status         = prx_pkg::ST_REPLY;
                        result.reply_sn       = item.pkt_sn;
                        result.reply_len_word = prx_pkg::LEN_LAST;
                        result.total_bytes    = received_total_reg;
                    end
                end
                else
                begin
                    result.store_write   = 1'b1;
                    result.store_address = dest_base_reg + {12'd0, received_total_reg};
                    result.store_length  = len;
                    if (item.store_fail)
                    begin
                        result.status         = prx_pkg::ST_ERROR;
                        result.reply_len_word = prx_pkg::LEN_LAST;
                        active_next           = 1'b0;
                    end
                    else
                    begin
                        received_total_next   = sum[19:0];
                        last_seen_next        = item.pkt_len_word[prx_pkg::LAST_BIT];
                        result.status         = prx_pkg::ST_REPLY;
                        result.reply_sn       = item.pkt_sn;
                        result.reply_len_word = prx_pkg::LEN_LAST;
                        result.total_bytes    = sum[19:0];
                    end
                end
            end
            else if ({28'd0, nak_inc} > 32'(NAK_LIMIT))
            begin
                result.status         = prx_pkg::ST_ERROR;
                result.reply_len_word = prx_pkg::LEN_LAST;
                active_next           = 1'b0;
            end
            else
            begin
                nak_count_next        = nak_inc[2:0];
                result.status         = prx_pkg::ST_REPLY;
                result.reply_sn       = item.pkt_sn;
                result.reply_len_word = item.crc_match ? prx_pkg::LEN_LAST
                                        : (prx_pkg::LEN_LAST | prx_pkg::LEN_CRC_ERR);
                result.total_bytes    = received_total_reg;
            end
        end

        // Any end of transfer returns the link state to idle.
        if (!active_next)
        begin
            expected_sn_next    = '0;
            nak_count_next      = '0;
            retry_count_next    = '0;
            received_total_next = '0;
            last_seen_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg       <= '0;
            dest_base_reg      <= '0;
            expected_sn_reg    <= '0;
            nak_count_reg      <= '0;
            retry_count_reg    <= '0;
            received_total_reg <= '0;
            last_seen_reg      <= 1'b0;
            active_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == prx_pkg::REG_CAPACITY)
            begin
                capacity_reg <= cfg_data[19:0];
            end
            if (cfg_we && cfg_addr == prx_pkg::REG_DEST_BASE)
            begin
                dest_base_reg <= cfg_data;
            end
            if (fire)
            begin
                expected_sn_reg    <= expected_sn_next;
                nak_count_reg      <= nak_count_next;
                retry_count_reg    <= retry_count_next;
                received_total_reg <= received_total_next;
                last_seen_reg      <= last_seen_next;
                active_reg         <= active_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/prx_out_stage.sv =====
// Result register of the packet receiver.
// Holds one result item until the downstream side takes it; uses prx_pkg.
`default_nettype none

module prx_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire prx_pkg::out_item_t result,
    output logic                    can_load,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output prx_pkg::out_item_t      m_item
);

    logic               valid_reg;
    logic               valid_next;
    prx_pkg::out_item_t item_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

// ===== sv/prx_checker.sv =====
// Port-level checker for the packet receiver, bound to the top level.
// Uses prx_pkg for status codes and length word constants.
`default_nettype none

module prx_port_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A wait result carries nothing else.
    a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == prx_pkg::ST_WAIT |-> m_axis_tdata == 96'd0)
        else $error("wait result with nonzero fields");

    // An error end packet has sequence number zero, the plain reply word and no total.
    a_error_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == prx_pkg::ST_ERROR |->
            m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[23:8] == prx_pkg::LEN_LAST
            && m_axis_tdata[88:69] == 20'd0)
        else $error("malformed error end packet");

    // Any reply word is either the ACK word or the CRC NAK word.
    a_reply_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != prx_pkg::ST_WAIT |->
            m_axis_tdata[23:8] == prx_pkg::LEN_LAST
            || m_axis_tdata[23:8] == (prx_pkg::LEN_LAST | prx_pkg::LEN_CRC_ERR))
        else $error("unexpected reply length word");

endmodule

bind packet_receiver_ack_nak_top prx_port_checker u_prx_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
